// File: sv/gasp_pkg.sv
`default_nettype none
package gasp_pkg;
	localparam int MaxGrid = 8;
	localparam int Cells = MaxGrid * MaxGrid;
	localparam int CoordW = $clog2(MaxGrid);
	localparam int IdxW = $clog2(Cells);
	localparam int CntW = IdxW + 1;
	localparam int CostW = 7;
	localparam int SizeW = 4;
	localparam logic [CostW-1:0] CostInf = '1;
	localparam logic [SizeW-1:0] SizeReset = SizeW'(MaxGrid);

	typedef logic [2:0] dir_t;
	localparam dir_t DirNone = 3'd0;
	localparam dir_t DirXm = 3'd1;
	localparam dir_t DirXp = 3'd2;
	localparam dir_t DirYm = 3'd3;
	localparam dir_t DirYp = 3'd4;

	// One per-cell record: cost, in-open flag and predecessor direction.
	typedef struct packed {
		logic [CostW-1:0] g;
		logic             open;
		dir_t             dir;
	} cell_rec_t;
	localparam int RecW = $bits(cell_rec_t);

	function automatic logic [CostW-1:0] heur(input logic [CoordW-1:0] a,
		input logic [CoordW-1:0] b, input logic [CoordW-1:0] c,
		input logic [CoordW-1:0] d);
		logic [2*CoordW:0] dx, dy;
		logic [2*CoordW:0] s;
		dx = (a > c) ? {{(CoordW+1){1'b0}}, a - c} : {{(CoordW+1){1'b0}}, c - a};
		dy = (b > d) ? {{(CoordW+1){1'b0}}, b - d} : {{(CoordW+1){1'b0}}, d - b};
		s = dx * dx + dy * dy;
		return CostW'(s);
	endfunction
endpackage
`default_nettype wire

// File: sv/gasp_ram.sv
`default_nettype none
module gasp_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: sv/grid_astar_path_search_unit.sv
// Channel | Direction | Handshake     | Payload
// in      | into      | valid/ready   | source_x source_y target_x target_y
// out     | out of    | o_valid/o_ready | cell_x cell_y found last_cell
// cfg     | into      | cfg_we        | cfg_data (active grid side)
// One search at a time. A search sweeps the 64-entry cell store once to clear it,
// then each expansion scans the open list entry by entry (read, wait, compare),
// shifts the entries behind the picked one, and does up to 4 neighbor
// read-modify-writes; the path walk then records the cells, and emission sends
// them out one per result, waiting while the last result is still unconsumed.
// Results wait in an output register, so the next request can be taken while the
// last result is still held; arst_n clears the state, grid size, o_valid and open count.
`default_nettype none
module grid_astar_path_search_unit
	import gasp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                valid,
	output logic                     ready,
	input  wire logic [CoordW-1:0]   source_x,
	input  wire logic [CoordW-1:0]   source_y,
	input  wire logic [CoordW-1:0]   target_x,
	input  wire logic [CoordW-1:0]   target_y,
	output logic                     o_valid,
	input  wire logic                o_ready,
	output logic [CoordW-1:0]        cell_x,
	output logic [CoordW-1:0]        cell_y,
	output logic                     found,
	output logic                     last_cell,
	input  wire logic                cfg_we,
	input  wire logic [SizeW-1:0]    cfg_data
);
	typedef enum logic [4:0] {
		S_IDLE, S_CLR, S_SCAN_RD, S_SCAN_WT, S_SCAN_CMP, S_PICK,
		S_SHIFT_RD, S_SHIFT_WT, S_SHIFT_WR, S_NB, S_NB_WT, S_NB_UPD,
		S_NB_CUR, S_NB_CURWT, S_WALK_RD, S_WALK_WT, S_EMIT_RD, S_EMIT_WT,
		S_EMIT, S_FAIL
	} state_t;

	state_t state_q;
	logic [SizeW-1:0] size_q;
	logic [CoordW-1:0] tx_q, ty_q;
	logic [IdxW-1:0] src_q, tgt_q, cur_q, ptr_q, best_q, nb_q, cell_q;
	logic [CntW-1:0] cnt_q, i_q, len_q;
	logic [CostW:0] bestf_q;
	logic [CostW-1:0] curg_q;
	logic [IdxW-1:0] clr_q;
	logic [2:0] nbk_q;
	logic [CoordW:0] n_w;

	// Cell store.
	logic cs_we;
	logic [IdxW-1:0] cs_wa, cs_ra;
	cell_rec_t cs_wd, cs_rd;
	logic [RecW-1:0] cs_rdv;
	// Open list.
	logic ol_we;
	logic [IdxW-1:0] ol_wa, ol_ra, ol_rd;
	// Path buffer.
	logic pb_we;
	logic [IdxW-1:0] pb_wa, pb_ra, pb_rd;

	logic [IdxW-1:0] ol_wd_w;
	logic [CoordW-1:0] cx_w, cy_w, bx_w, by_w;
	logic nb_ok;
	dir_t nb_code;
	logic [IdxW-1:0] nb_idx;
	logic [CostW:0] f_w;
	logic [IdxW-1:0] ol_cell_s2;
	dir_t nb_dirq, curdir_q;

	gasp_ram #(.Width(RecW), .Depth(Cells)) u_cell (
		.clk, .we(cs_we), .waddr(cs_wa), .wdata(cs_wd), .raddr(cs_ra), .rdata(cs_rdv));
	assign cs_rd = cell_rec_t'(cs_rdv);
	gasp_ram #(.Width(IdxW), .Depth(Cells)) u_open (
		.clk, .we(ol_we), .waddr(ol_wa), .wdata(ol_wd_w), .raddr(ol_ra), .rdata(ol_rd));
	gasp_ram #(.Width(IdxW), .Depth(Cells)) u_path (
		.clk, .we(pb_we), .waddr(pb_wa), .wdata(cell_q), .raddr(pb_ra), .rdata(pb_rd));

	assign n_w = (size_q > SizeW'(MaxGrid)) ? (CoordW+1)'(MaxGrid) : (CoordW+1)'(size_q);
	assign ready = (state_q == S_IDLE);
	assign cx_w = cur_q[CoordW-1:0];
	assign cy_w = cur_q[IdxW-1:CoordW];
	assign bx_w = cell_q[CoordW-1:0];
	assign by_w = cell_q[IdxW-1:CoordW];
	assign f_w = (CostW+1)'(cs_rd.g) + (CostW+1)'(heur(ol_cell_s2[CoordW-1:0],
		ol_cell_s2[IdxW-1:CoordW], tx_q, ty_q));

	// Neighbor candidate for the current step.
	always_comb begin
		nb_ok = 1'b0;
		nb_code = DirNone;
		nb_idx = cur_q;
		unique case (nbk_q)
			3'd0: begin
				nb_ok = (cx_w != '0); nb_code = DirXp; nb_idx = cur_q - IdxW'(1);
			end
			3'd1: begin
				nb_ok = ((CoordW+1)'(cx_w) + 1'b1 < n_w); nb_code = DirXm;
				nb_idx = cur_q + IdxW'(1);
			end
			3'd2: begin
				nb_ok = (cy_w != '0); nb_code = DirYp; nb_idx = cur_q - IdxW'(MaxGrid);
			end
			3'd3: begin
				nb_ok = ((CoordW+1)'(cy_w) + 1'b1 < n_w); nb_code = DirYm;
				nb_idx = cur_q + IdxW'(MaxGrid);
			end
			default: nb_ok = 1'b0;
		endcase
	end

	always_comb begin
		cs_we = 1'b0; cs_wa = clr_q; cs_wd = '{g: CostInf, open: 1'b0, dir: DirNone};
		cs_ra = cur_q;
		ol_we = 1'b0; ol_wa = ptr_q; ol_wd_w = ol_rd; ol_ra = ptr_q;
		pb_we = 1'b0; pb_wa = len_q[IdxW-1:0]; pb_ra = ptr_q;
		unique case (state_q)
			S_CLR: begin
				cs_we = 1'b1;
				if (clr_q == src_q) cs_wd = '{g: '0, open: 1'b1, dir: DirNone};
				ol_we = (clr_q == '0); ol_wa = '0; ol_wd_w = src_q;
			end
			S_SCAN_RD: ol_ra = i_q[IdxW-1:0];
			S_SCAN_WT: cs_ra = ol_rd;
			S_SHIFT_RD: ol_ra = ptr_q + IdxW'(1);
			S_SHIFT_WT: ol_ra = ptr_q + IdxW'(1);
			S_SHIFT_WR: begin ol_we = 1'b1; ol_wa = ptr_q; ol_wd_w = ol_rd; end
			S_NB: cs_ra = nb_idx;
			S_NB_WT: cs_ra = nb_q;
			S_NB_UPD: begin
				if (curg_q + 1'b1 < cs_rd.g) begin
					cs_we = 1'b1; cs_wa = nb_q;
					cs_wd = '{g: curg_q + 1'b1, open: 1'b1, dir: nb_dirq};
					if (!cs_rd.open) begin
						ol_we = 1'b1; ol_wa = cnt_q[IdxW-1:0]; ol_wd_w = nb_q;
					end
				end
			end
			S_NB_CUR: begin
				// Drop the expanded cell from the open set.
				cs_we = 1'b1; cs_wa = cur_q;
				cs_wd = '{g: curg_q, open: 1'b0, dir: curdir_q};
			end
			S_WALK_RD: begin
				cs_ra = cell_q;
				pb_we = 1'b1;
			end
			S_EMIT_RD: pb_ra = ptr_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			size_q <= SizeReset;
			o_valid <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) size_q <= cfg_data;
			if (o_valid && o_ready) o_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (valid && ready) begin
						src_q <= {source_y, source_x};
						tgt_q <= {target_y, target_x};
						tx_q <= target_x; ty_q <= target_y;
						clr_q <= '0;
						if ((CoordW+1)'(source_x) >= n_w || (CoordW+1)'(source_y) >= n_w ||
							(CoordW+1)'(target_x) >= n_w || (CoordW+1)'(target_y) >= n_w)
							state_q <= S_FAIL;
						else state_q <= S_CLR;
					end
				end
				S_FAIL: begin
					if (!o_valid) begin
						o_valid <= 1'b1; cell_x <= '0; cell_y <= '0;
						found <= 1'b0; last_cell <= 1'b1; state_q <= S_IDLE;
					end
				end
				S_CLR: begin
					clr_q <= clr_q + IdxW'(1);
					if (clr_q == IdxW'(Cells - 1)) begin
						cnt_q <= CntW'(1);
						i_q <= '0; bestf_q <= '1; state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_WT;
				S_SCAN_WT: begin ol_cell_s2 <= ol_rd; state_q <= S_SCAN_CMP; end
				S_SCAN_CMP: begin
					if (i_q == '0 || f_w < bestf_q) begin
						bestf_q <= f_w; best_q <= i_q[IdxW-1:0];
						cur_q <= ol_cell_s2; curg_q <= cs_rd.g; curdir_q <= cs_rd.dir;
					end
					i_q <= i_q + 1'b1;
					state_q <= (i_q + 1'b1 < cnt_q) ? S_SCAN_RD : S_PICK;
				end
				S_PICK: begin
					if (cnt_q == '0) state_q <= S_FAIL;
					else if (cur_q == tgt_q) begin
						cell_q <= tgt_q; len_q <= '0; state_q <= S_WALK_RD;
					end else begin
						ptr_q <= best_q;
						state_q <= (CntW'(best_q) + 1'b1 < cnt_q) ? S_SHIFT_RD : S_NB_CUR;
					end
				end
				S_SHIFT_RD: state_q <= S_SHIFT_WT;
				S_SHIFT_WT: state_q <= S_SHIFT_WR;
				S_SHIFT_WR: begin
					ptr_q <= ptr_q + IdxW'(1);
					state_q <= (CntW'(ptr_q) + 2'd2 < cnt_q) ? S_SHIFT_RD : S_NB_CUR;
				end
				S_NB_CUR: begin
					cnt_q <= cnt_q - 1'b1; nbk_q <= '0; state_q <= S_NB;
				end
				S_NB: begin
					if (nbk_q == 3'd4) begin
						i_q <= '0; bestf_q <= '1;
						state_q <= (cnt_q == '0) ? S_PICK : S_SCAN_RD;
					end else if (nb_ok) begin
						nb_q <= nb_idx; nb_dirq <= nb_code; state_q <= S_NB_WT;
					end else nbk_q <= nbk_q + 3'd1;
				end
				S_NB_WT: state_q <= S_NB_UPD;
				S_NB_UPD: begin
					if (curg_q + 1'b1 < cs_rd.g && !cs_rd.open && cnt_q < CntW'(Cells))
						cnt_q <= cnt_q + 1'b1;
					nbk_q <= nbk_q + 3'd1; state_q <= S_NB;
				end
				S_WALK_RD: begin
					len_q <= len_q + 1'b1; state_q <= S_WALK_WT;
				end
				S_WALK_WT: begin
					state_q <= S_EMIT_RD; ptr_q <= len_q[IdxW-1:0] - IdxW'(1);
					if (len_q < CntW'(Cells)) begin
						unique case (cs_rd.dir)
							DirXm: if (bx_w != '0) begin
								cell_q <= cell_q - IdxW'(1); state_q <= S_WALK_RD; end
							DirXp: if (bx_w != '1) begin
								cell_q <= cell_q + IdxW'(1); state_q <= S_WALK_RD; end
							DirYm: if (by_w != '0) begin
								cell_q <= cell_q - IdxW'(MaxGrid); state_q <= S_WALK_RD; end
							DirYp: if (by_w != '1) begin
								cell_q <= cell_q + IdxW'(MaxGrid); state_q <= S_WALK_RD; end
							default: ;
						endcase
					end
				end
				S_EMIT_RD: state_q <= S_EMIT_WT;
				S_EMIT_WT: state_q <= S_EMIT;
				S_EMIT: begin
					if (!o_valid) begin
						o_valid <= 1'b1;
						cell_x <= pb_rd[CoordW-1:0]; cell_y <= pb_rd[IdxW-1:CoordW];
						found <= 1'b1; last_cell <= (ptr_q == '0);
						ptr_q <= ptr_q - IdxW'(1);
						state_q <= (ptr_q == '0) ? S_IDLE : S_EMIT_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(Cells)) else $error("open count overflow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !o_ready |=> o_valid && $stable(cell_x) && $stable(last_cell))
		else $error("result dropped");
	a_fail_nf: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !found |-> last_cell) else $error("failure not last");
`endif
endmodule
`default_nettype wire
